@@ sv/tbc_pkg.sv @@
// Shared types and constants for the translation block cache.
// No dependencies.
package tbc_pkg;
    localparam int ENTRIES     = 8;
    localparam int SLOT_W      = $clog2(ENTRIES);
    localparam int ADDR_BITS   = 16;
    localparam int ORDER_DEPTH = 16;
    localparam int QPTR_W      = $clog2(ORDER_DEPTH);
    localparam int QFILL_W     = QPTR_W + 1;
    localparam int CNT_W       = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        OP_LOOKUP     = 2'd0,
        OP_COMPILE    = 2'd1,
        OP_INVALIDATE = 2'd2,
        OP_NONE       = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_MISS    = 3'd1,
        ST_COMPILE = 3'd2,
        ST_FAIL    = 3'd3,
        ST_RANGE   = 3'd4,
        ST_INVAL   = 3'd5,
        ST_NOENT   = 3'd6,
        ST_NOROOM  = 3'd7
    } status_t;

    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_PROGLEN  = 2'd1;
    localparam logic [1:0] CFG_FAILURES = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_EVICT,
        S_INSERT,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic decide;    // resolve lookup/invalidate/failure path
        logic evict_pop; // pop one queue entry and evict it if present
        logic insert;    // place the new block
        logic out_load;  // move result to output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_insert; // after decide: compile miss that will insert
        logic need_evict;  // occupied count at capacity
        logic queue_empty;
        logic evict_hit;   // head key is occupied
    } dp_stat_t;
endpackage

@@ sv/tbc_ctrl.sv @@
// Controller state machine for the translation block cache.
// Depends on tbc_pkg.
module tbc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  tbc_pkg::dp_stat_t stat,
    output tbc_pkg::dp_cmd_t  cmd
);
    import tbc_pkg::*;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        mvalid_next = mvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                if (stat.need_insert)
                    state_next = stat.need_evict ? S_EVICT : S_INSERT;
                else
                    state_next = S_OUT;
            end
            S_EVICT: begin
                if (stat.queue_empty) begin
                    state_next = S_INSERT;
                end else begin
                    cmd.evict_pop = 1'b1;
                    if (stat.evict_hit) state_next = S_INSERT;
                end
            end
            S_INSERT: begin
                cmd.insert = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                // output register must be free
                if (!mvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_out_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> state_reg == S_OUT)
        else $error("result loaded outside output state");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> state_reg == S_DECIDE)
        else $error("accepted item not decided");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!mvalid_reg || m_tready))
        else $error("pending result overwritten");
`endif
endmodule

@@ sv/tbc_datapath.sv @@
// Datapath of the translation block cache: slots, age queue, counters, output register.
// Depends on tbc_pkg.
module tbc_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  tbc_pkg::dp_cmd_t  cmd,
    output tbc_pkg::dp_stat_t stat,
    input  logic [1:0]        in_opcode,
    input  logic [15:0]       in_guest_pc,
    input  logic [16:0]       in_block_end,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [16:0]       cfg_data,
    output logic [2:0]        out_status,
    output logic [16:0]       out_found_end,
    output logic [31:0]       out_found_generation,
    output logic [3:0]        out_live_count,
    output logic [31:0]       out_compiled_count
);
    import tbc_pkg::*;

    logic [3:0]  capacity_reg;
    logic [16:0] prog_len_reg;
    logic [7:0]  fail_left_reg;

    logic [ENTRIES-1:0] used_reg, valid_reg;
    logic [ADDR_BITS-1:0] key_mem [ENTRIES];
    logic [16:0] end_mem [ENTRIES];
    logic [31:0] gen_mem [ENTRIES];

    logic [ADDR_BITS-1:0] queue_mem [ORDER_DEPTH];
    logic [QPTR_W-1:0]    head_reg;
    logic [QFILL_W-1:0]   fill_reg;

    logic [31:0] gen_cnt_reg, total_reg;

    logic [1:0]           op_reg;
    logic [ADDR_BITS-1:0] pc_reg;
    logic [16:0]          bend_reg;

    logic [2:0]  st_reg;
    logic [16:0] fend_reg;
    logic [31:0] fgen_reg;

    logic [2:0]  o_status_reg;
    logic [16:0] o_end_reg;
    logic [31:0] o_gen_reg;
    logic [3:0]  o_live_reg;
    logic [31:0] o_total_reg;

    // associative match on the held key
    logic [ENTRIES-1:0] match, head_match;
    logic               hit_any, valid_hit;
    logic [SLOT_W-1:0]  hit_idx, free_idx;
    logic               free_any;
    logic [16:0]        hit_end;
    logic [31:0]        hit_gen;
    logic [CNT_W-1:0]   used_cnt, live_cnt;
    logic [ADDR_BITS-1:0] head_key;

    always_comb begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        used_cnt = '0;
        live_cnt = '0;
        head_key = queue_mem[head_reg];
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]      = used_reg[i] && (key_mem[i] == pc_reg);
            head_match[i] = used_reg[i] && (key_mem[i] == head_key);
            used_cnt = used_cnt + CNT_W'(used_reg[i]);
            live_cnt = live_cnt + CNT_W'(used_reg[i] && valid_reg[i]);
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_any = 1'b1;
                hit_idx = SLOT_W'(i);
            end
        end
        // lowest free slot wins
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
        valid_hit = hit_any && valid_reg[hit_idx];
        hit_end   = end_mem[hit_idx];
        hit_gen   = gen_mem[hit_idx];
    end

    assign stat.need_insert = (op_reg == OP_COMPILE) && !valid_hit
                              && (fail_left_reg == '0) && ({1'b0, pc_reg} < prog_len_reg);
    assign stat.need_evict  = (4'(used_cnt) >= capacity_reg);
    assign stat.queue_empty = (fill_reg == '0);
    assign stat.evict_hit   = |head_match;

    logic [SLOT_W-1:0] evict_idx;
    always_comb begin
        evict_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
            if (head_match[i]) evict_idx = SLOT_W'(i);
    end

    logic [SLOT_W-1:0] ins_idx;
    logic              ins_ok;
    assign ins_ok  = hit_any || free_any;
    assign ins_idx = hit_any ? hit_idx : free_idx;

    logic [31:0] gen_inc;
    assign gen_inc = gen_cnt_reg + 32'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg  <= 4'd8;
            prog_len_reg  <= '0;
            fail_left_reg <= '0;
            used_reg      <= '0;
            valid_reg     <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            gen_cnt_reg   <= '0;
            total_reg     <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_CAPACITY: capacity_reg  <= cfg_data[3:0];
                    CFG_PROGLEN:  prog_len_reg  <= cfg_data;
                    CFG_FAILURES: fail_left_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (cmd.decide) begin
                if ((op_reg == OP_COMPILE) && !valid_hit && fail_left_reg != '0)
                    fail_left_reg <= fail_left_reg - 8'd1;
                if ((op_reg == OP_INVALIDATE) && hit_any)
                    valid_reg[hit_idx] <= 1'b0;
            end
            if (cmd.evict_pop) begin
                head_reg <= head_reg + QPTR_W'(1);
                fill_reg <= fill_reg - QFILL_W'(1);
                if (|head_match) begin
                    used_reg[evict_idx]  <= 1'b0;
                    valid_reg[evict_idx] <= 1'b0;
                end
            end
            if (cmd.insert && ins_ok) begin
                used_reg[ins_idx]  <= 1'b1;
                valid_reg[ins_idx] <= 1'b1;
                gen_cnt_reg <= gen_inc;
                total_reg   <= total_reg + 32'd1;
                if (fill_reg == QFILL_W'(ORDER_DEPTH))
                    head_reg <= head_reg + QPTR_W'(1);
                else
                    fill_reg <= fill_reg + QFILL_W'(1);
            end
        end
    end

    logic [QPTR_W-1:0] push_ptr;
    assign push_ptr = (fill_reg == QFILL_W'(ORDER_DEPTH)) ? head_reg
                      : head_reg + fill_reg[QPTR_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_opcode;
            pc_reg   <= in_guest_pc;
            bend_reg <= in_block_end;
        end
        if (cmd.decide) begin
            unique case (op_reg) inside
                OP_LOOKUP, OP_COMPILE: begin
                    fend_reg <= valid_hit ? hit_end : '0;
                    fgen_reg <= valid_hit ? hit_gen : '0;
                    if (valid_hit)
                        st_reg <= ST_HIT;
                    else if (op_reg == OP_LOOKUP)
                        st_reg <= ST_MISS;
                    else if (fail_left_reg != '0)
                        st_reg <= ST_FAIL;
                    else
                        st_reg <= ST_RANGE; // replaced on insert
                end
                OP_INVALIDATE: begin
                    st_reg   <= hit_any ? ST_INVAL : ST_NOENT;
                    fend_reg <= '0;
                    fgen_reg <= '0;
                end
                default: begin
                    st_reg   <= ST_NOENT;
                    fend_reg <= '0;
                    fgen_reg <= '0;
                end
            endcase
        end
        if (cmd.insert) begin
            if (ins_ok) begin
                key_mem[ins_idx]   <= pc_reg;
                end_mem[ins_idx]   <= bend_reg;
                gen_mem[ins_idx]   <= gen_inc;
                queue_mem[push_ptr] <= pc_reg;
                st_reg   <= ST_COMPILE;
                fend_reg <= bend_reg;
                fgen_reg <= gen_inc;
            end else begin
                st_reg <= ST_NOROOM;
            end
        end
        if (cmd.out_load) begin
            o_status_reg <= st_reg;
            o_end_reg    <= fend_reg;
            o_gen_reg    <= fgen_reg;
            o_live_reg   <= 4'(live_cnt);
            o_total_reg  <= total_reg;
        end
    end

    assign out_status           = o_status_reg;
    assign out_found_end        = o_end_reg;
    assign out_found_generation = o_gen_reg;
    assign out_live_count       = o_live_reg;
    assign out_compiled_count   = o_total_reg;

`ifndef NO_ASSERTIONS
    a_valid_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg & ~used_reg) == '0)
        else $error("valid slot not occupied");
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= QFILL_W'(ORDER_DEPTH))
        else $error("queue overfilled");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.evict_pop |-> fill_reg != '0)
        else $error("pop from empty queue");
`endif
endmodule

@@ sv/translation_block_cache_top.sv @@
// Top level of the translation block cache: controller plus datapath.
// Depends on tbc_pkg, tbc_ctrl, tbc_datapath.
//
// Usage: one command item on the s_ stream (opcode, guest_pc, block_end)
// gives exactly one result item on the m_ stream (status, found_end,
// found_generation, live_count, compiled_count).
// Each accepted item passes through the decide and output states; a compile
// that inserts also passes through insert and, when the slots are at capacity,
// through evict first, which pops age-queue entries until one holds an occupied
// key to evict or the queue runs empty (at most ORDER_DEPTH entries popped).
// One item is in flight at a time; s_tready returns the cycle after the
// result is loaded, so no new item is taken before the last one is done.
// The result sits in an output register; the next item is accepted while
// it waits, but a new result is not written until the old one is taken,
// so a stalled receiver stalls the block after one further item.
// Reset (aresetn low, synchronous) empties every slot and the age queue,
// clears the counters and loads capacity 8, program_length 0, failures 0.
// Configuration must be written via cfg_we/cfg_index/cfg_data only while idle;
// not enforced; writing failure_count reloads the remaining-failures counter.
module translation_block_cache_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // opcode[1:0], guest_pc[17:2], block_end[34:18]
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], found_end[19:3], found_generation[51:20],
    // live_count[55:52], compiled_count[87:56]
    output logic [87:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    import tbc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tbc_datapath u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .stat                 (stat),
        .in_opcode            (s_tdata[1:0]),
        .in_guest_pc          (s_tdata[17:2]),
        .in_block_end         (s_tdata[34:18]),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .out_status           (m_tdata[2:0]),
        .out_found_end        (m_tdata[19:3]),
        .out_found_generation (m_tdata[51:20]),
        .out_live_count       (m_tdata[55:52]),
        .out_compiled_count   (m_tdata[87:56])
    );
endmodule

@@ dv/tb_translation_block_cache_top.sv @@
// Self-checking testbench for translation_block_cache_top: drives command items,
// predicts each result with a behavioral cache model and compares fields.
// Depends on tbc_pkg and the RTL of translation_block_cache_top.
module tb_translation_block_cache_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tbc_pkg::*;

    typedef struct packed {
        logic [16:0] block_end;
        logic [15:0] guest_pc;
        opcode_t     opcode;
    } cmd_t;

    typedef struct packed {
        logic [31:0] compiled_count;
        logic [3:0]  live_count;
        logic [31:0] found_generation;
        logic [16:0] found_end;
        status_t     status;
    } res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_CAPACITY;
    logic [16:0] cfg_data = '0;

    translation_block_cache_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // cache prediction state
    logic [3:0]  cap_q;
    logic [16:0] proglen_q;
    logic [7:0]  fails_left;
    logic        used_q [ENTRIES];
    logic        valid_q[ENTRIES];
    logic [15:0] key_q  [ENTRIES];
    logic [16:0] end_q  [ENTRIES];
    logic [31:0] gen_q  [ENTRIES];
    logic [15:0] age_q  [$];
    logic [31:0] gen_ctr;
    logic [31:0] compiles;

    cmd_t pending_cmds[$];
    res_t expected_results[$];
    int   errors = 0;
    bit   quiet = 0;      // no idling in the last part
    bit   hold_send = 0;

    function automatic int find_key(logic [15:0] k);
        for (int i = 0; i < ENTRIES; i++)
            if (used_q[i] && key_q[i] == k) return i;
        return -1;
    endfunction

    function automatic res_t predict_cache(cmd_t c);
        res_t r;
        int   s, n;
        r = '0;
        r.status = ST_NOENT;
        s = find_key(c.guest_pc);
        if (c.opcode == OP_LOOKUP || c.opcode == OP_COMPILE) begin
            if (s >= 0 && valid_q[s]) begin
                r.status = ST_HIT;
                r.found_end = end_q[s];
                r.found_generation = gen_q[s];
            end else if (c.opcode == OP_LOOKUP) begin
                r.status = ST_MISS;
            end else if (fails_left != 0) begin
                fails_left--;
                r.status = ST_FAIL;
            end else if ({1'b0, c.guest_pc} >= proglen_q) begin
                r.status = ST_RANGE;
            end else begin
                n = 0;
                for (int i = 0; i < ENTRIES; i++) n += used_q[i];
                if (n >= cap_q) begin
                    // walk the age order past keys that are gone
                    while (age_q.size() > 0) begin
                        int e;
                        e = find_key(age_q[0]);
                        age_q.delete(0);
                        if (e >= 0) begin
                            used_q[e] = 0;
                            valid_q[e] = 0;
                            break;
                        end
                    end
                end
                s = find_key(c.guest_pc);
                for (int i = 0; i < ENTRIES && s < 0; i++)
                    if (!used_q[i]) s = i;
                if (s < 0) begin
                    r.status = ST_NOROOM;
                end else begin
                    gen_ctr++;
                    used_q[s] = 1;
                    valid_q[s] = 1;
                    key_q[s] = c.guest_pc;
                    end_q[s] = c.block_end;
                    gen_q[s] = gen_ctr;
                    if (age_q.size() >= ORDER_DEPTH) age_q.delete(0);
                    age_q = {age_q, c.guest_pc};
                    compiles++;
                    r.status = ST_COMPILE;
                    r.found_end = c.block_end;
                    r.found_generation = gen_ctr;
                end
            end
        end else if (c.opcode == OP_INVALIDATE && s >= 0) begin
            valid_q[s] = 0;
            r.status = ST_INVAL;
        end
        n = 0;
        for (int i = 0; i < ENTRIES; i++) n += used_q[i] && valid_q[i];
        r.live_count = 4'(n);
        r.compiled_count = compiles;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial forever #10 aclk = ~aclk;

    // driver: item moves when valid and ready meet
    int send_gap = 0;
    always @(posedge aclk) begin
        cmd_t next_cmd;
        res_t pred;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pred = predict_cache(cmd_t'(s_tdata[34:0]));
                expected_results = {expected_results, pred};
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (!hold_send && pending_cmds.size() > 0) begin
                    next_cmd = pending_cmds[0];
                    pending_cmds.delete(0);
                    s_tdata  <= 40'(next_cmd);
                    s_tvalid <= 1'b1;
                    if (!quiet && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 13);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor plus receiver stalls
    int recv_gap = 0;
    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata);
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 64'(got.status), 64'(0));
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (got.status != want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.found_end != want.found_end)
                        report_mismatch("found_end", 64'(got.found_end),
                                        64'(want.found_end));
                    if (got.found_generation != want.found_generation)
                        report_mismatch("found_generation", 64'(got.found_generation),
                                        64'(want.found_generation));
                    if (got.live_count != want.live_count)
                        report_mismatch("live_count", 64'(got.live_count),
                                        64'(want.live_count));
                    if (got.compiled_count != want.compiled_count)
                        report_mismatch("compiled_count", 64'(got.compiled_count),
                                        64'(want.compiled_count));
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(0, 12);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic cmd_t make_cmd(opcode_t op, logic [15:0] pc, logic [16:0] be);
        cmd_t c;
        c.opcode = op;
        c.guest_pc = pc;
        c.block_end = be;
        return c;
    endfunction

    task automatic enqueue_cmd(opcode_t op, logic [15:0] pc, logic [16:0] be);
        pending_cmds = {pending_cmds, make_cmd(op, pc, be)};
    endtask

    // checked twice so an item popped at the sampling edge is not missed
    task automatic wait_drained();
        repeat (2) begin
            while (pending_cmds.size() > 0 || s_tvalid || expected_results.size() > 0)
                @(posedge aclk);
            repeat (2) @(posedge aclk);
        end
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [16:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CAPACITY: cap_q = val[3:0];
            CFG_PROGLEN:  proglen_q = val;
            CFG_FAILURES: fails_left = val[7:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // random phase: small key pool to get hits, evictions and reinserts
    task automatic queue_random(int count, int pool);
        opcode_t op;
        logic [15:0] pc;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9)) inside
                0, 1:    op = OP_LOOKUP;
                2:       op = OP_INVALIDATE;
                3:       op = OP_NONE;
                default: op = OP_COMPILE;
            endcase
            if ($urandom_range(0, 7) == 0) pc = 16'($urandom);
            else pc = 16'hFFF0 ^ 16'($urandom_range(0, pool - 1));
            enqueue_cmd(op, pc, 17'($urandom_range(1, 65536)));
        end
    endtask

    initial begin
        cap_q = 4'd8;
        proglen_q = '0;
        fails_left = '0;
        gen_ctr = '0;
        compiles = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            used_q[i] = 0;
            valid_q[i] = 0;
            key_q[i] = '0;
            end_q[i] = '0;
            gen_q[i] = '0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // out of range with program_length 0, then opened up
        enqueue_cmd(OP_COMPILE, 16'h0000, 17'd1);
        enqueue_cmd(OP_NONE, 16'hFFFF, 17'h1FFFF);
        wait_drained();
        write_cfg(CFG_PROGLEN, 17'd65536);
        write_cfg(CFG_FAILURES, 17'd2);
        enqueue_cmd(OP_COMPILE, 16'h0000, 17'd65536);
        enqueue_cmd(OP_COMPILE, 16'h0000, 17'd65536);
        enqueue_cmd(OP_COMPILE, 16'h0000, 17'd65536);
        enqueue_cmd(OP_COMPILE, 16'h0000, 17'd5);
        enqueue_cmd(OP_LOOKUP, 16'h0000, 17'd0);
        enqueue_cmd(OP_LOOKUP, 16'hFFFF, 17'd0);
        enqueue_cmd(OP_INVALIDATE, 16'h0000, 17'd0);
        enqueue_cmd(OP_INVALIDATE, 16'hFFFF, 17'd0);
        enqueue_cmd(OP_COMPILE, 16'h0000, 17'd7);
        enqueue_cmd(OP_COMPILE, 16'hFFFF, 17'h1FFFF);
        for (int i = 1; i <= 9; i++)
            enqueue_cmd(OP_COMPILE, 16'(i * 7), 17'(i));
        // sender pause: everything in flight must come back first
        while (pending_cmds.size() > 10) @(posedge aclk);
        hold_send = 1;
        while (s_tvalid || expected_results.size() > 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        hold_send = 0;
        wait_drained();
        // capacity 0 evicts every time; above ENTRIES can run out of room
        write_cfg(CFG_CAPACITY, 17'd0);
        enqueue_cmd(OP_COMPILE, 16'h1234, 17'd3);
        enqueue_cmd(OP_COMPILE, 16'h1235, 17'd3);
        wait_drained();
        write_cfg(CFG_CAPACITY, 17'd15);
        for (int i = 0; i < 20; i++)
            enqueue_cmd(OP_COMPILE, 16'(16'h2000 + i), 17'd9);
        wait_drained();

        write_cfg(CFG_CAPACITY, 17'd1);
        write_cfg(CFG_PROGLEN, 17'd0);
        queue_random(40, 6);
        wait_drained();
        write_cfg(CFG_PROGLEN, 17'hFFF8);
        write_cfg(CFG_FAILURES, 17'd255);
        queue_random(40, 6);
        wait_drained();
        write_cfg(CFG_FAILURES, 17'd0);
        write_cfg(CFG_CAPACITY, 17'd4);
        write_cfg(CFG_PROGLEN, 17'd65536);
        queue_random(200, 12);
        wait_drained();
        write_cfg(CFG_CAPACITY, 17'd8);
        write_cfg(CFG_FAILURES, 17'd5);
        queue_random(200, 20);
        wait_drained();
        write_cfg(CFG_CAPACITY, 17'd10);
        queue_random(150, 10);
        while (pending_cmds.size() > 40) @(posedge aclk);
        quiet = 1;
        wait_drained();

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
